FILE: sv/spq_pkg.sv
// Package for the stable priority queue: widths, command and status codes,
// and the control struct broadcast to the cell chain. No dependencies.
package spq_pkg;

  localparam int VAL_W          = 32;
  localparam int IN_PRIO_W      = 8;
  localparam int OCC_W          = 5;
  localparam int DEPTH_DEF      = 16;
  localparam int PRIO_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // operation applied to every cell in the same cycle
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

FILE: sv/stable_priority_queue.sv
// The result is registered at the edge that accepts its transaction.
// Throughput: one item per cycle; the cell chain shifts by one slot per cycle.
// The input stalls only while a finished result is held and the output stalls.
// Reset (rst_n low, synchronous) clears the occupancy count and output valid;
// slot contents are not cleared and no clearing pass is needed.
// Top level: count, command decode, output register; depends on spq_pkg, spq_cell.
module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic signed [VAL_W-1:0]     in_item_value,
  input  logic [IN_PRIO_W-1:0]        in_item_priority,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_W-1:0]     out_head_value,
  output logic [1:0]                  out_status,
  output logic                        out_now_empty,
  output logic [OCC_W-1:0]            out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    in_fire, full, empty, enq_ok, deq_ok;
  spq_ctl_t                ctl;
  logic [PRIO_BITS-1:0]    new_pri;

  logic signed [VAL_W-1:0] vals [DEPTH];
  logic [PRIO_BITS-1:0]    pris [DEPTH];
  logic                    afters [DEPTH];

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] head_r, head_nxt;
  logic [1:0]              status_r, status_nxt;
  logic                    empty_r;
  logic [OCC_W-1:0]        occ_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign enq_ok   = in_fire && (in_cmd == CMD_ENQ) && !full;
  assign deq_ok   = in_fire && (in_cmd == CMD_DEQ) && !empty;
  assign ctl      = '{enq: enq_ok, deq: deq_ok};
  assign new_pri  = PRIO_BITS'(in_item_priority);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                    al;
      logic signed [VAL_W-1:0] lv, rv;
      logic [PRIO_BITS-1:0]    lp, rp;
      if (g == 0) begin : g_first
        assign al = 1'b1;
        assign lv = in_item_value;
        assign lp = new_pri;
      end else begin : g_mid
        assign al = afters[g-1];
        assign lv = vals[g-1];
        assign lp = pris[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rv = '0;
        assign rp = '0;
      end else begin : g_inner
        assign rv = vals[g+1];
        assign rp = pris[g+1];
      end
      spq_cell #(
        .IDX       (g),
        .CNT_W     (CNT_W),
        .PRIO_BITS (PRIO_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cnt        (cnt_r),
        .new_val    (in_item_value),
        .new_pri    (new_pri),
        .after_left (al),
        .left_val   (lv),
        .left_pri   (lp),
        .right_val  (rv),
        .right_pri  (rp),
        .after      (afters[g]),
        .val_o      (vals[g]),
        .pri_o      (pris[g])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt    = cnt_r;
    head_nxt   = '0;
    status_nxt = ST_OK;
    if (enq_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (deq_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    unique case (in_cmd)
      CMD_ENQ: begin
        if (full) status_nxt = ST_OVER;
      end
      CMD_DEQ, CMD_PEEK: begin
        if (empty) status_nxt = ST_UNDER;
        else head_nxt = vals[0];
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    out_valid_nxt = in_fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      head_r   <= head_nxt;
      status_r <= status_nxt;
      empty_r  <= cnt_nxt == '0;
      occ_r    <= OCC_W'(cnt_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_head_value = head_r;
  assign out_status     = status_r;
  assign out_now_empty  = empty_r;
  assign out_occupancy  = occ_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_ENQ) && full |=> out_status == ST_OVER && !out_now_empty)
    else $error("overflow not reported");

  a_head_ins: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok && empty |=> vals[0] == $past(in_item_value))
    else $error("insert into empty queue missed the head slot");

endmodule

FILE: sv/spq_cell.sv
// One slot of the sorted chain: holds a data word and a priority, shifts
// right on insert and left on remove. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  spq_ctl_t                    ctl,
  input  logic [CNT_W-1:0]            cnt,
  input  logic signed [VAL_W-1:0]     new_val,
  input  logic [PRIO_BITS-1:0]        new_pri,
  input  logic                        after_left,
  input  logic signed [VAL_W-1:0]     left_val,
  input  logic [PRIO_BITS-1:0]        left_pri,
  input  logic signed [VAL_W-1:0]     right_val,
  input  logic [PRIO_BITS-1:0]        right_pri,
  output logic                        after,
  output logic signed [VAL_W-1:0]     val_o,
  output logic [PRIO_BITS-1:0]        pri_o
);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [PRIO_BITS-1:0]    pri_r, pri_nxt;
  logic                    occupied;

  assign occupied = CNT_W'(IDX) < cnt;
  // new item goes behind this slot (stable on equal priority)
  assign after    = occupied && (pri_r <= new_pri);

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (ctl.enq) begin
      if (!after_left) begin
        val_nxt = left_val;
        pri_nxt = left_pri;
      end else if (!after) begin
        val_nxt = new_val;
        pri_nxt = new_pri;
      end
    end else if (ctl.deq) begin
      val_nxt = right_val;
      pri_nxt = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val_o = val_r;
  assign pri_o = pri_r;

endmodule
